>>> hdl/x86_shift_rotate_flags_unit_top_defines.svh
// Assertion macros for the shift and rotate unit checker.
`ifndef X86_SHIFT_ROTATE_FLAGS_UNIT_TOP_DEFINES_SVH
`define X86_SHIFT_ROTATE_FLAGS_UNIT_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define XSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define XSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> hdl/xsr_pkg.sv
// Package with the types and constants of the shift and rotate unit.
`default_nettype none
package xsr_pkg;
    localparam int unsigned Lat = 3;

    typedef enum logic [2:0] {
        OP_SAR = 3'd0, OP_SHR = 3'd1, OP_SHL = 3'd2, OP_SHRD = 3'd3,
        OP_SHLD = 3'd4, OP_ROL = 3'd5, OP_ROR = 3'd6, OP_BAD = 3'd7
    } op_t;

    localparam logic [1:0] SZ_8 = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    // Decoded item after stage one.
    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  sz;
        logic [63:0] src;
        logic [63:0] fill;
        logic [6:0]  w;
        logic [6:0]  e;      // effective shift amount
        logic [5:0]  c;
        logic        active;
        logic        exceeds;
    } dec_t;

    // Shifted item after stage two.
    typedef struct packed {
        logic [63:0] res;
        logic        cf;
        logic        of;
        logic        wr_c;
        logic        wr_o;
        logic        wr_szp;
        logic        exceeds;
        logic [1:0]  sz;
    } shf_t;

    function automatic logic [63:0] width_mask(input logic [1:0] sz);
        case (sz)
            SZ_8:    width_mask = 64'h0000_0000_0000_00FF;
            SZ_16:   width_mask = 64'h0000_0000_0000_FFFF;
            SZ_32:   width_mask = 64'h0000_0000_FFFF_FFFF;
            default: width_mask = '1;
        endcase
    endfunction

    function automatic logic top_bit(input logic [63:0] v, input logic [1:0] sz);
        case (sz)
            SZ_8:    top_bit = v[7];
            SZ_16:   top_bit = v[15];
            SZ_32:   top_bit = v[31];
            default: top_bit = v[63];
        endcase
    endfunction
endpackage
`default_nettype wire

>>> hdl/xsr_decode.sv
// Stage one: masks operands and the count and works out the shift amount.
`default_nettype none
module xsr_decode (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [2:0]    op,
    input  wire logic [1:0]    op_size,
    input  wire logic [63:0]   source_value,
    input  wire logic [63:0]   fill_value,
    input  wire logic [7:0]    count,
    output logic               dec_valid,
    output xsr_pkg::dec_t      dec
);
    logic          valid_reg;
    xsr_pkg::dec_t dec_reg, dec_next;

    always_comb
    begin
        logic [63:0] m;
        logic [6:0]  w;
        logic [5:0]  c;
        m = xsr_pkg::width_mask(op_size);
        w = 7'd8 << op_size;
        c = (op_size == xsr_pkg::SZ_64) ? count[5:0] : {1'b0, count[4:0]};
        dec_next.op = op;
        dec_next.sz = op_size;
        dec_next.src = source_value & m;
        dec_next.fill = fill_value & m;
        dec_next.w = w;
        dec_next.c = c;
        dec_next.exceeds = ({1'b0, c} > w);
        dec_next.active = (c != 6'd0) && (op != xsr_pkg::OP_BAD);
        if (op == xsr_pkg::OP_ROL || op == xsr_pkg::OP_ROR)
            dec_next.e = {1'b0, c} & (w - 7'd1);
        else if ({1'b0, c} > w)
            dec_next.e = w;
        else
            dec_next.e = {1'b0, c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign dec_valid = valid_reg;
    assign dec = dec_reg;
endmodule
`default_nettype wire

>>> hdl/xsr_shift.sv
// Stage two: funnel shift that gives the result, CF and OF.
`default_nettype none
module xsr_shift (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          dec_valid,
    input  wire xsr_pkg::dec_t dec,
    output logic               shf_valid,
    output xsr_pkg::shf_t      shf
);
    logic          valid_reg;
    xsr_pkg::shf_t shf_reg, shf_next;

    always_comb
    begin
        logic [63:0]  m;
        logic [63:0]  hi;
        logic [127:0] pair;
        logic [127:0] rpair;
        logic [127:0] lpair;
        logic [127:0] lsh;
        logic [6:0]   wl;
        logic [63:0]  res;
        logic         cf;
        logic         of;
        logic         t;
        logic         t1;
        m = xsr_pkg::width_mask(dec.sz);
        wl = dec.w - dec.e;
        // Upper word of the funnel: fill for double shifts, copy for rotates,
        // sign for SAR, zero otherwise.
        case (dec.op)
            xsr_pkg::OP_SAR:
                hi = xsr_pkg::top_bit(dec.src, dec.sz) ? m : 64'd0;
            xsr_pkg::OP_SHRD, xsr_pkg::OP_SHLD:
                hi = dec.fill;
            xsr_pkg::OP_ROL, xsr_pkg::OP_ROR:
                hi = dec.src;
            default:
                hi = 64'd0;
        endcase
        // Pair is hi:src aligned at the operand width.
        pair = {64'd0, dec.src} | ({64'd0, hi} << dec.w);
        rpair = pair >> dec.e;
        // Left forms: src:hi shifted left by e, taking the top w bits.
        lpair = ({64'd0, hi} | ({64'd0, dec.src} << dec.w)) << dec.e;
        lsh = lpair >> dec.w;
        cf = 1'b0;
        of = 1'b0;
        res = dec.src;
        case (dec.op)
            xsr_pkg::OP_SAR, xsr_pkg::OP_SHR, xsr_pkg::OP_SHRD, xsr_pkg::OP_ROR:
            begin
                res = rpair[63:0] & m;
                cf = (dec.e == 7'd0) ? 1'b0 : pair[dec.e - 7'd1];
            end
            xsr_pkg::OP_SHL, xsr_pkg::OP_SHLD, xsr_pkg::OP_ROL:
            begin
                res = lsh[63:0] & m;
                cf = (dec.e == 7'd0) ? 1'b0 : pair[wl];
            end
            default:
                res = dec.src;
        endcase
        t = xsr_pkg::top_bit(res, dec.sz);
        t1 = xsr_pkg::top_bit({res[62:0], 1'b0}, dec.sz);
        case (dec.op)
            xsr_pkg::OP_SAR:  of = 1'b0;
            xsr_pkg::OP_SHR:
            begin
                // Beyond the width every bit shifted out is zero.
                if (dec.exceeds)
                    cf = 1'b0;
                of = xsr_pkg::top_bit(dec.src, dec.sz);
            end
            xsr_pkg::OP_SHL:
            begin
                if (dec.c > dec.w[5:0] && dec.w != 7'd64)
                    cf = 1'b0;
                of = t ^ cf;
            end
            xsr_pkg::OP_SHRD: of = xsr_pkg::top_bit(dec.src, dec.sz) ^ t;
            xsr_pkg::OP_SHLD: of = t ^ cf;
            xsr_pkg::OP_ROL:
            begin
                cf = res[0];
                of = t ^ cf;
            end
            xsr_pkg::OP_ROR:
            begin
                cf = t;
                of = t ^ t1;
            end
            default: of = 1'b0;
        endcase
        shf_next.res = dec.active ? res : dec.src;
        shf_next.wr_c = dec.active;
        shf_next.wr_o = dec.active && (dec.c == 6'd1);
        shf_next.wr_szp = dec.active && dec.op != xsr_pkg::OP_ROL
                          && dec.op != xsr_pkg::OP_ROR;
        shf_next.cf = dec.active & cf;
        shf_next.of = dec.active && (dec.c == 6'd1) && of;
        shf_next.exceeds = dec.exceeds;
        shf_next.sz = dec.sz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= dec_valid;
    end

    always_ff @(posedge clk)
    begin
        shf_reg <= shf_next;
    end

    assign shf_valid = valid_reg;
    assign shf = shf_reg;
endmodule
`default_nettype wire

>>> hdl/xsr_flags.sv
// Stage three: zero, sign and parity flags and the output register.
`default_nettype none
module xsr_flags (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shf_valid,
    input  wire xsr_pkg::shf_t shf,
    output logic               done,
    output logic [63:0]        result,
    output logic               carry_flag,
    output logic               overflow_flag,
    output logic               zero_flag,
    output logic               sign_flag,
    output logic               parity_flag,
    output logic               carry_written,
    output logic               overflow_written,
    output logic               szp_written,
    output logic               count_exceeds_width
);
    logic        done_reg;
    logic [63:0] res_reg;
    logic [8:0]  fl_reg, fl_next;

    always_comb
    begin
        fl_next[0] = shf.cf;
        fl_next[1] = shf.of;
        fl_next[2] = shf.wr_szp && (shf.res == 64'd0);
        fl_next[3] = shf.wr_szp && xsr_pkg::top_bit(shf.res, shf.sz);
        fl_next[4] = shf.wr_szp && !(^shf.res[7:0]);
        fl_next[5] = shf.wr_c;
        fl_next[6] = shf.wr_o;
        fl_next[7] = shf.wr_szp;
        fl_next[8] = shf.exceeds;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= shf_valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= shf.res;
        fl_reg <= fl_next;
    end

    assign done = done_reg;
    assign result = res_reg;
    assign carry_flag = fl_reg[0];
    assign overflow_flag = fl_reg[1];
    assign zero_flag = fl_reg[2];
    assign sign_flag = fl_reg[3];
    assign parity_flag = fl_reg[4];
    assign carry_written = fl_reg[5];
    assign overflow_written = fl_reg[6];
    assign szp_written = fl_reg[7];
    assign count_exceeds_width = fl_reg[8];
endmodule
`default_nettype wire

>>> hdl/x86_shift_rotate_flags_unit_top.sv
// Top level of the x86 shift and rotate unit with flag generation.
// The unit takes one beat on every cycle in which start is high (busy is
// always low, since the pipeline never stalls) and shows the result, once it
// has passed the decode, shift and flag registers, on done for one cycle;
// the receiver must take it then, as it cannot hold results off. The three
// stages are decode, funnel shift and flag generation, and every item passes
// through all three whatever the operation or count.
`default_nettype none
module x86_shift_rotate_flags_unit_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  op,
    input  wire logic [1:0]  op_size,
    input  wire logic [63:0] source_value,
    input  wire logic [63:0] fill_value,
    input  wire logic [7:0]  count,
    output logic             done,
    output logic [63:0]      result,
    output logic             carry_flag,
    output logic             overflow_flag,
    output logic             zero_flag,
    output logic             sign_flag,
    output logic             parity_flag,
    output logic             carry_written,
    output logic             overflow_written,
    output logic             szp_written,
    output logic             count_exceeds_width
);
    logic          dec_valid;
    logic          shf_valid;
    xsr_pkg::dec_t dec;
    xsr_pkg::shf_t shf;

    // The pipeline moves every cycle, so it is never busy.
    assign busy = 1'b0;

    xsr_decode u_decode (
        .clk(clk), .rst_n(rst_n), .in_valid(start && !busy), .op(op),
        .op_size(op_size), .source_value(source_value), .fill_value(fill_value),
        .count(count), .dec_valid(dec_valid), .dec(dec)
    );

    xsr_shift u_shift (
        .clk(clk), .rst_n(rst_n), .dec_valid(dec_valid), .dec(dec),
        .shf_valid(shf_valid), .shf(shf)
    );

    xsr_flags u_flags (
        .clk(clk), .rst_n(rst_n), .shf_valid(shf_valid), .shf(shf), .done(done),
        .result(result), .carry_flag(carry_flag), .overflow_flag(overflow_flag),
        .zero_flag(zero_flag), .sign_flag(sign_flag), .parity_flag(parity_flag),
        .carry_written(carry_written), .overflow_written(overflow_written),
        .szp_written(szp_written), .count_exceeds_width(count_exceeds_width)
    );
endmodule
`default_nettype wire

>>> hdl/xsr_checker.sv
// Port checker for the shift and rotate unit, bound to the top level.
`default_nettype none
`include "x86_shift_rotate_flags_unit_top_defines.svh"
module xsr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic carry_flag,
    input wire logic overflow_flag,
    input wire logic carry_written,
    input wire logic overflow_written,
    input wire logic szp_written,
    input wire logic zero_flag
);
    `XSR_ASSERT_IMP(a_of_needs_cf, clk, rst_n, done && overflow_written, carry_written)
    `XSR_ASSERT_IMP(a_cf_gated, clk, rst_n, done && !carry_written, !carry_flag && !overflow_flag)
    `XSR_ASSERT_IMP(a_zf_gated, clk, rst_n, done && !szp_written, !zero_flag)
    `XSR_ASSERT_NEXT(a_latency, clk, rst_n, start && !busy, ##2 done)
endmodule
bind x86_shift_rotate_flags_unit_top xsr_checker u_xsr_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .carry_flag(carry_flag), .overflow_flag(overflow_flag),
    .carry_written(carry_written), .overflow_written(overflow_written),
    .szp_written(szp_written), .zero_flag(zero_flag)
);
`default_nettype wire

>>> dv/x86_shift_rotate_flags_unit_checker.sv
// Checker that predicts and compares every result of the shift and rotate unit.
module x86_shift_rotate_flags_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  op,
    input  logic [1:0]  op_size,
    input  logic [63:0] source_value,
    input  logic [63:0] fill_value,
    input  logic [7:0]  count,
    input  logic        done,
    input  logic [63:0] result,
    input  logic        carry_flag,
    input  logic        overflow_flag,
    input  logic        zero_flag,
    input  logic        sign_flag,
    input  logic        parity_flag,
    input  logic        carry_written,
    input  logic        overflow_written,
    input  logic        szp_written,
    input  logic        count_exceeds_width,
    output int          error_count,
    output int          pending_count
);

    typedef struct packed {
        logic [63:0] value;
        logic        cf;
        logic        of;
        logic        zf;
        logic        sf;
        logic        pf;
        logic        wr_c;
        logic        wr_o;
        logic        wr_szp;
        logic        exceeds;
    } shift_outcome_t;

    shift_outcome_t expected_outcomes[$];

    function automatic logic bit_at(input logic [63:0] v, input int pos);
        return (pos >= 0 && pos < 64) ? v[pos] : 1'b0;
    endfunction

    function automatic shift_outcome_t predict_shift(input logic [2:0] opc,
                                                     input logic [1:0] sz,
                                                     input logic [63:0] src_in,
                                                     input logic [63:0] fill_in,
                                                     input logic [7:0] raw_count);
        shift_outcome_t o;
        int w, c, e, r, top;
        logic [63:0] m, src, fill, sx, res;
        logic signed [63:0] sxs;
        logic cf, of;
        w = 8 << sz;
        top = w - 1;
        m = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
        src = src_in & m;
        fill = fill_in & m;
        c = int'(raw_count & ((w == 64) ? 8'h3F : 8'h1F));
        o = '0;
        res = src;
        cf = 1'b0;
        of = 1'b0;
        o.exceeds = (c > w);
        if (c != 0 && xsr_pkg::op_t'(opc) != xsr_pkg::OP_BAD)
        begin
            o.wr_c = 1'b1;
            o.wr_o = (c == 1);
            case (xsr_pkg::op_t'(opc))
                xsr_pkg::OP_SAR:
                begin
                    sx = src[top] ? (src | ~m) : src;
                    sxs = sx;
                    sxs = sxs >>> c;
                    res = sxs & m;
                    cf = bit_at(sx, c - 1);
                    o.wr_szp = 1'b1;
                end
                xsr_pkg::OP_SHR:
                begin
                    res = (src >> c) & m;
                    cf = bit_at(src, c - 1);
                    of = src[top];
                    o.wr_szp = 1'b1;
                end
                xsr_pkg::OP_SHL:
                begin
                    res = (src << c) & m;
                    cf = (c <= w) ? bit_at(src, w - c) : 1'b0;
                    of = res[top] ^ cf;
                    o.wr_szp = 1'b1;
                end
                xsr_pkg::OP_SHRD, xsr_pkg::OP_SHLD:
                begin
                    // Double shifts saturate the count at the operand width.
                    e = (c > w) ? w : c;
                    if (xsr_pkg::op_t'(opc) == xsr_pkg::OP_SHRD)
                    begin
                        res = ((src >> e) | (fill << (w - e))) & m;
                        cf = bit_at(src, e - 1);
                        of = src[top] ^ res[top];
                    end
                    else
                    begin
                        res = ((src << e) | (fill >> (w - e))) & m;
                        cf = bit_at(src, w - e);
                        of = res[top] ^ cf;
                    end
                    o.wr_szp = 1'b1;
                end
                default:
                begin
                    r = c & (w - 1);
                    if (r != 0)
                    begin
                        if (xsr_pkg::op_t'(opc) == xsr_pkg::OP_ROL)
                            res = ((src << r) | (src >> (w - r))) & m;
                        else
                            res = ((src >> r) | (src << (w - r))) & m;
                    end
                    if (xsr_pkg::op_t'(opc) == xsr_pkg::OP_ROL)
                    begin
                        cf = res[0];
                        of = res[top] ^ cf;
                    end
                    else
                    begin
                        cf = res[top];
                        of = cf ^ res[top - 1];
                    end
                end
            endcase
        end
        o.value = res;
        o.cf = o.wr_c ? cf : 1'b0;
        o.of = o.wr_o ? of : 1'b0;
        if (o.wr_szp)
        begin
            o.zf = (res == 64'd0);
            o.sf = res[top];
            o.pf = ~(^res[7:0]);
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        shift_outcome_t got, want;
        if (!rst_n)
        begin
            expected_outcomes.delete();
            error_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (done)
            begin
                got = '{result, carry_flag, overflow_flag, zero_flag, sign_flag,
                        parity_flag, carry_written, overflow_written, szp_written,
                        count_exceeds_width};
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: result beat with none expected: %h", $time, got);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (got != want)
                    begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_outcomes.push_back(predict_shift(op, op_size, source_value,
                                                          fill_value, count));
            pending_count <= expected_outcomes.size();
        end
    end

endmodule

>>> dv/tb_x86_shift_rotate_flags_unit_top.sv
// Testbench top: stimulus for the shift and rotate unit and the final verdict.
module tb_x86_shift_rotate_flags_unit_top;

    localparam int RandomBeats = 1330;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [1:0]  op_size;
    logic [63:0] source_value;
    logic [63:0] fill_value;
    logic [7:0]  count;
    logic        done;
    logic [63:0] result;
    logic        carry_flag, overflow_flag, zero_flag, sign_flag, parity_flag;
    logic        carry_written, overflow_written, szp_written, count_exceeds_width;
    int          error_count;
    int          pending_count;
    // Percentage of cycles in which the sender leaves start low.
    int          idle_pct;

    x86_shift_rotate_flags_unit_top DUT (.*);

    x86_shift_rotate_flags_unit_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #200000;
        $display("DONE: errors detected");
        $finish;
    end

    // Presents one beat, with random idle cycles in front of it, and holds it
    // until the unit takes it.
    task automatic issue_shift(input xsr_pkg::op_t o, input logic [1:0] sz,
                               input logic [63:0] src, input logic [63:0] fill,
                               input logic [7:0] cnt);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        op           <= o;
        op_size      <= sz;
        source_value <= src;
        fill_value   <= fill;
        count        <= cnt;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Three in eight values have a hard edge (all ones, a lone set bit, zero),
    // the rest are fully random so that every bit toggles.
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Counts cluster around the interesting points: one, the width and the
    // masking boundaries; the rest spread over the whole byte.
    function automatic logic [7:0] pick_count(input logic [1:0] sz);
        int w;
        w = 8 << sz;
        case ($urandom_range(7))
            0: return 8'd1;
            1: return w[7:0];
            2: return w[7:0] + 8'd1;
            3: return 8'(($urandom_range(3) * 32) + $urandom_range(1));
            4: return 8'($urandom_range(w));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial
    begin
        xsr_pkg::op_t o;
        logic [1:0] sz;
        start        <= 1'b0;
        op           <= xsr_pkg::OP_SAR;
        op_size      <= xsr_pkg::SZ_8;
        source_value <= '0;
        fill_value   <= '0;
        count        <= '0;
        idle_pct     = 0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats: every operation, each width, zero count, a count of
        // one, counts at and beyond the width for the narrow sizes, masking of
        // the raw count, rotates that reduce to zero, and the invalid code.
        issue_shift(xsr_pkg::OP_SAR, xsr_pkg::SZ_8,  64'h80, 64'h0, 8'd3);
        issue_shift(xsr_pkg::OP_SAR, xsr_pkg::SZ_16, 64'h8001, 64'h0, 8'd20);
        issue_shift(xsr_pkg::OP_SAR, xsr_pkg::SZ_64, '1, '1, 8'd63);
        issue_shift(xsr_pkg::OP_SAR, xsr_pkg::SZ_64, 64'h8000_0000_0000_0000, 64'h0, 8'd60);
        issue_shift(xsr_pkg::OP_SHR, xsr_pkg::SZ_32, 64'h8000_0001, 64'h0, 8'd1);
        issue_shift(xsr_pkg::OP_SHR, xsr_pkg::SZ_8,  64'hFF, 64'h0, 8'd9);
        issue_shift(xsr_pkg::OP_SHL, xsr_pkg::SZ_8,  64'h81, 64'h0, 8'd8);
        issue_shift(xsr_pkg::OP_SHL, xsr_pkg::SZ_16, 64'hFFFF, 64'h0, 8'd17);
        issue_shift(xsr_pkg::OP_SHL, xsr_pkg::SZ_64, 64'h1, 64'h0, 8'd1);
        issue_shift(xsr_pkg::OP_SHRD, xsr_pkg::SZ_8, 64'hA5, 64'h3C, 8'd12);
        issue_shift(xsr_pkg::OP_SHRD, xsr_pkg::SZ_64, '1, 64'h0, 8'd1);
        issue_shift(xsr_pkg::OP_SHLD, xsr_pkg::SZ_16, 64'h1234, 64'hABCD, 8'd16);
        issue_shift(xsr_pkg::OP_SHLD, xsr_pkg::SZ_32, 64'h8000_0000, '1, 8'd31);
        issue_shift(xsr_pkg::OP_ROL, xsr_pkg::SZ_8,  64'h81, 64'h0, 8'd16);
        issue_shift(xsr_pkg::OP_ROL, xsr_pkg::SZ_64, 64'h8000_0000_0000_0000, 64'h0, 8'd1);
        issue_shift(xsr_pkg::OP_ROR, xsr_pkg::SZ_16, 64'h0001, 64'h0, 8'd1);
        issue_shift(xsr_pkg::OP_ROR, xsr_pkg::SZ_32, 64'hDEAD_BEEF, 64'h0, 8'd31);
        issue_shift(xsr_pkg::OP_SHR, xsr_pkg::SZ_64, '1, '1, 8'd64);
        issue_shift(xsr_pkg::OP_SHL, xsr_pkg::SZ_32, '1, '1, 8'd255);
        issue_shift(xsr_pkg::OP_BAD, xsr_pkg::SZ_8,  '1, '1, 8'd30);
        issue_shift(xsr_pkg::OP_BAD, xsr_pkg::SZ_64, 64'h5555, 64'h0, 8'd5);
        issue_shift(xsr_pkg::OP_SAR, xsr_pkg::SZ_64, 64'h7FFF_FFFF_FFFF_FFFF, '1, 8'd0);

        // The sender holds back here until the unit has drained completely.
        start <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);

        // Random beats in three phases of idling: none, heavy, moderate.
        for (int i = 0; i < RandomBeats; i++)
        begin
            idle_pct = (i < 450) ? 0 : (i < 900) ? 56 : 28;
            o = ($urandom_range(19) == 0) ? xsr_pkg::OP_BAD
                                          : xsr_pkg::op_t'($urandom_range(6));
            sz = 2'($urandom_range(3));
            issue_shift(o, sz, pick_operand(), pick_operand(), pick_count(sz));
        end
        start <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (xsr_pkg::Lat + 3) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
